>>> sv/oaie_pkg.sv
// Shared types and constants for the ordered array insert/erase core.
package oaie_pkg;

	localparam int DEPTH = 16;
	localparam int WIDTH = 32;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;

	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_INSERT = 3'd2;
	localparam logic [2:0] CMD_ERASE  = 3'd3;
	localparam logic [2:0] CMD_RANGE  = 3'd4;
	localparam logic [2:0] CMD_READ   = 3'd5;
	localparam logic [2:0] CMD_CLEAR  = 3'd6;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_INDEX = 2'd2;
	localparam logic [1:0] STS_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [IDX_W-1:0] index;
		logic [IDX_W-1:0] index_end;
		logic [WIDTH-1:0] value;
	} req_t;

	typedef struct packed {
		logic [WIDTH-1:0] read_value;
		logic [CNT_W-1:0] count;
		logic [1:0]       status;
	} rsp_t;

	// broadcast to every cell; each cell decodes its own move
	typedef struct packed {
		logic             append;
		logic             insert;
		logic             shift;
		logic [IDX_W-1:0] pos;
		logic [CNT_W-1:0] held;
		logic [WIDTH-1:0] value;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_RANGE
	} state_t;

endpackage

>>> sv/oaie_cell.sv
// One storage cell of the list: holds a word, loads or takes a neighbor's word.
module oaie_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  oaie_pkg::cell_ctl_t         ctl,
	input  logic [oaie_pkg::WIDTH-1:0]  left_word,
	input  logic [oaie_pkg::WIDTH-1:0]  right_word,
	output logic [oaie_pkg::WIDTH-1:0]  word
);
	import oaie_pkg::*;

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

	logic [WIDTH-1:0] word_q;
	logic [CNT_W-1:0] pos_ext;

	assign pos_ext = CNT_W'(ctl.pos);
	assign word = word_q;

	always_ff @(posedge clk) begin
		if (ctl.append && MY_POS == ctl.held) begin
			word_q <= ctl.value;
		end else if (ctl.insert && MY_POS == pos_ext) begin
			word_q <= ctl.value;
		end else if (ctl.insert && MY_POS > pos_ext && MY_POS <= ctl.held) begin
			word_q <= left_word;
		end else if (ctl.shift && MY_POS >= pos_ext) begin
			word_q <= right_word;
		end
	end

endmodule

>>> sv/oaie_ctrl.sv
// Command decode, count, range-erase sequencer and result register.
module oaie_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  oaie_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output oaie_pkg::rsp_t              rsp,
	input  logic [oaie_pkg::WIDTH-1:0]  words [oaie_pkg::DEPTH],
	output oaie_pkg::cell_ctl_t         ctl
);
	import oaie_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	logic             rsp_valid_q, rsp_valid_d;
	rsp_t             rsp_q, rsp_d;
	logic             ld_out;
	logic             req_acc;
	logic             out_free;
	logic [CNT_W-1:0] held_m1;
	logic [CNT_W-1:0] idx_ext;
	logic [CNT_W-1:0] end_ext;

	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign held_m1   = held_q - 1'b1;
	assign idx_ext   = CNT_W'(req.index);
	assign end_ext   = CNT_W'(req.index_end);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		rem_d   = rem_q;
		pos_d   = pos_q;
		ld_out  = 1'b0;
		rsp_d   = '0;
		ctl        = '0;
		ctl.held   = held_q;
		ctl.value  = req.value;
		ctl.pos    = (state_q == ST_IDLE) ? req.index : pos_q;

		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					ld_out = 1'b1;
					case (req.cmd)
						CMD_APPEND: begin
							if (held_q == CNT_W'(DEPTH)) begin
								rsp_d.status = STS_FULL;
							end else begin
								ctl.append = 1'b1;
								held_d = held_q + 1'b1;
							end
						end
						CMD_POP: begin
							if (held_q == '0) begin
								rsp_d.status = STS_EMPTY;
							end else begin
								rsp_d.read_value = words[held_m1[IDX_W-1:0]];
								held_d = held_m1;
							end
						end
						CMD_INSERT: begin
							if (held_q == '0) begin
								rsp_d.status = STS_EMPTY;
							end else if (idx_ext > held_q) begin
								rsp_d.status = STS_INDEX;
							end else if (held_q == CNT_W'(DEPTH)) begin
								rsp_d.status = STS_FULL;
							end else begin
								ctl.insert = 1'b1;
								held_d = held_q + 1'b1;
							end
						end
						CMD_ERASE: begin
							if (held_q == '0) begin
								rsp_d.status = STS_EMPTY;
							end else if (idx_ext >= held_q) begin
								rsp_d.status = STS_INDEX;
							end else begin
								rsp_d.read_value = words[req.index];
								ctl.shift = 1'b1;
								held_d = held_m1;
							end
						end
						CMD_RANGE: begin
							if (held_q == '0) begin
								rsp_d.status = STS_EMPTY;
							end else if (idx_ext > end_ext || end_ext >= held_q) begin
								rsp_d.status = STS_INDEX;
							end else begin
								// result comes after the row has closed the gap
								ld_out  = 1'b0;
								state_d = ST_RANGE;
								pos_d   = req.index;
								rem_d   = end_ext - idx_ext + 1'b1;
							end
						end
						CMD_READ: begin
							if (held_q == '0) begin
								rsp_d.status = STS_EMPTY;
							end else if (idx_ext >= held_q) begin
								rsp_d.status = STS_INDEX;
							end else begin
								rsp_d.read_value = words[req.index];
							end
						end
						CMD_CLEAR: begin
							held_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RANGE: begin
				if (rem_q != '0) begin
					// one place down per cycle
					ctl.shift = 1'b1;
					held_d = held_m1;
					rem_d  = rem_q - 1'b1;
				end else if (out_free) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rsp_d.count = held_d;

		if (ld_out) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			held_q      <= held_d;
			rem_q       <= rem_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (ld_out) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_range_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RANGE |-> req_stall)
		else $error("command taken during range erase");

	a_range_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANGE && rem_q != '0) |=> held_q == $past(held_q) - 1'b1)
		else $error("range step did not drop the count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == STS_FULL) |-> rsp_q.count == CNT_W'(DEPTH))
		else $error("full status with room left");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !ld_out)
		else $error("result overwritten while stalled");
`endif

endmodule

>>> sv/ordered_array_insert_erase_core.sv
// Top level: a row of word cells and the command controller.
//
// Ordered list of up to 16 32-bit words held in a row of cells that shift
// together. Append, remove last, insert, erase one, read and clear each
// complete without holding the input: a command is taken every cycle while
// the result register is free or being drained. Erase range moves the row
// down one place per cycle and holds the input until its result has been
// loaded into the result register. Every command returns one beat with the
// read or removed word, the new count and a status (ok, empty, bad index,
// full). Entries come out of reset undefined; only positions below the
// count are ever read.
module ordered_array_insert_erase_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  oaie_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output oaie_pkg::rsp_t  rsp
);
	import oaie_pkg::*;

	logic [WIDTH-1:0] words [DEPTH];
	cell_ctl_t        ctl;

	oaie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.words     (words),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		oaie_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_word  (words[(i == 0) ? 0 : i - 1]),
			.right_word (words[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
			.word       (words[i])
		);
	end

endmodule
